/* rtl/lcss_pkg.sv */
package lcss_pkg;

  // Array and field sizes
  localparam int unsigned MAX_SERVERS = 256;
  localparam int unsigned IDX_W       = $clog2(MAX_SERVERS);
  localparam int unsigned AVOID_W     = 9;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned WIDE_W      = 64;
  localparam int unsigned TIE_W       = 9;
  localparam int unsigned PRNG_W      = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [TIE_W-1:0] TIE_MAX = '1;

  // Server roles as carried on the request channel
  typedef enum logic [1:0] {
    ROLE_OFF      = 2'd0,
    ROLE_ACTIVE   = 2'd1,
    ROLE_BACKUP   = 2'd2,
    ROLE_FALLBACK = 2'd3
  } role_t;

  // Pass outcome codes
  typedef enum logic [1:0] {
    OUT_CHOSEN   = 2'd0,
    OUT_NONE     = 2'd1,
    OUT_FALLBACK = 2'd2
  } outcome_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HAS_ACTIVE   = 3'd0,
    REG_HAS_FALLBACK = 3'd1,
    REG_CACHE_USABLE = 3'd2,
    REG_AVOID        = 3'd3,
    REG_SEED         = 3'd4
  } cfg_reg_t;

endpackage

/* rtl/lcss_ifs.sv */
// Server request channel
interface lcss_in_if;
  import lcss_pkg::*;
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    server_index;
  logic [1:0]          server_role;
  logic [CNT_W-1:0]    served;
  logic [CNT_W-1:0]    queued;
  logic [CNT_W-1:0]    conn_limit;
  logic [CNT_W-1:0]    queue_limit;
  logic                lookup_ok;
  logic                remote_found;
  logic [WIDE_W-1:0]   cached_total;
  logic [WIDE_W-1:0]   cached_self;
  logic [WIDE_W-1:0]   current_local;
  logic                last_server;

  modport source (
    output valid, server_index, server_role, served, queued, conn_limit, queue_limit,
           lookup_ok, remote_found, cached_total, cached_self, current_local, last_server,
    input  ready
  );
  modport sink (
    input  valid, server_index, server_role, served, queued, conn_limit, queue_limit,
           lookup_ok, remote_found, cached_total, cached_self, current_local, last_server,
    output ready
  );
endinterface

// Selection result channel
interface lcss_out_if;
  import lcss_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       outcome;
  logic [IDX_W-1:0] selected_server;

  modport source (output valid, outcome, selected_server, input ready);
  modport sink   (input valid, outcome, selected_server, output ready);
endinterface

// Configuration write channel
interface lcss_cfg_if;
  import lcss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/least_conn_server_select.sv */
// Least-connections server selection.
// in_ch carries one request per server of a selection pass; last_server marks
// the final request. Each eligible server with spare capacity is scored as
// its remote count (global minus own) plus its local count; the lowest score
// wins and equal scores are settled by a reservoir draw from an internal
// xorshift32. The avoided server is chosen only when nothing else qualifies.
// A failed lookup, a global count below own count, a 64-bit overflow or an
// unusable cache makes the pass report fallback.
// out_ch carries one result per pass, registered: the last request of a pass
// passes the input and scoring registers before out_ch.valid rises.
// Throughput is one request per cycle: an input register, a scoring register
// and the running best-score state form a three-deep pipeline, and the only
// loop is the 64-bit compare and 32x9 draw multiply against the running best.
// cfg_ch is always ready; write it only while no pass is in flight.
// Reset (rst_n low, synchronous) clears the pipeline and pass state, loads
// the registers with their defaults and seeds the generator with 1.
// When out_ch stalls, requests keep flowing until the next last request
// reaches the scoring register; it then waits there for the result slot.
module least_conn_server_select (
  input  logic        clk,
  input  logic        rst_n,
  lcss_in_if.sink     in_ch,
  lcss_out_if.source  out_ch,
  lcss_cfg_if.sink    cfg_ch
);
  import lcss_pkg::*;

  // Configuration registers
  logic               has_active_r;
  logic               has_fallback_r;
  logic               cache_usable_r;
  logic [AVOID_W-1:0] avoid_r;

  // Input register
  logic               s1_valid_r;
  logic [IDX_W-1:0]   s1_idx_r;
  role_t              s1_role_r;
  logic [CNT_W-1:0]   s1_served_r;
  logic [CNT_W-1:0]   s1_queued_r;
  logic [CNT_W-1:0]   s1_climit_r;
  logic [CNT_W-1:0]   s1_qlimit_r;
  logic               s1_ok_r;
  logic               s1_found_r;
  logic [WIDE_W-1:0]  s1_global_r;
  logic [WIDE_W-1:0]  s1_own_r;
  logic [WIDE_W-1:0]  s1_local_r;
  logic               s1_last_r;

  // Scoring register
  logic               s2_valid_r;
  logic [IDX_W-1:0]   s2_idx_r;
  logic               s2_cand_r;
  logic               s2_fb_r;
  logic [WIDE_W-1:0]  s2_score_r;
  logic               s2_last_r;

  // Pass state
  logic               best_valid_r, best_valid_nxt;
  logic [IDX_W-1:0]   best_index_r, best_index_nxt;
  logic [WIDE_W-1:0]  best_cost_r, best_cost_nxt;
  logic [TIE_W-1:0]   tie_count_r, tie_count_nxt;
  logic               avoided_r, avoided_nxt;
  logic               fallback_r, fallback_nxt;
  logic [PRNG_W-1:0]  prng_r, prng_nxt;

  // Result register
  logic               out_valid_r;
  outcome_t           out_outcome_r;
  logic [IDX_W-1:0]   out_server_r;

  // Handshake and flow control
  logic out_free, s2_room, s1_room, s2_take, in_fire, cfg_fire;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s2_room  = !s2_valid_r || !s2_last_r || out_free;
  assign s1_room  = !s1_valid_r || s2_room;
  assign s2_take  = s2_valid_r && s2_room;
  assign in_fire  = in_ch.valid && s1_room;
  assign cfg_fire = cfg_ch.valid;

  assign in_ch.ready    = s1_room;
  assign cfg_ch.ready   = 1'b1;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.outcome = out_outcome_r;
  assign out_ch.selected_server = out_server_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_active_r   <= 1'b0;
      has_fallback_r <= 1'b0;
      cache_usable_r <= 1'b0;
      avoid_r        <= AVOID_W'(MAX_SERVERS);
    end else if (cfg_fire) begin
      unique case (cfg_ch.index)
        REG_HAS_ACTIVE:   has_active_r   <= cfg_ch.data[0];
        REG_HAS_FALLBACK: has_fallback_r <= cfg_ch.data[0];
        REG_CACHE_USABLE: cache_usable_r <= cfg_ch.data[0];
        REG_AVOID:        avoid_r        <= cfg_ch.data[AVOID_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_room) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // Input register: payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx_r    <= in_ch.server_index;
      s1_role_r   <= role_t'(in_ch.server_role);
      s1_served_r <= in_ch.served;
      s1_queued_r <= in_ch.queued;
      s1_climit_r <= in_ch.conn_limit;
      s1_qlimit_r <= in_ch.queue_limit;
      s1_ok_r     <= in_ch.lookup_ok;
      s1_found_r  <= in_ch.remote_found;
      s1_global_r <= in_ch.cached_total;
      s1_own_r    <= in_ch.cached_self;
      s1_local_r  <= in_ch.current_local;
      s1_last_r   <= in_ch.last_server;
    end
  end

  // Eligibility by role and tier
  logic elig;
  always_comb begin
    priority if (s1_role_r == ROLE_OFF) begin
      elig = 1'b0;
    end else if (has_active_r) begin
      elig = (s1_role_r == ROLE_ACTIVE);
    end else if (has_fallback_r) begin
      elig = (s1_role_r == ROLE_FALLBACK);
    end else begin
      elig = (s1_role_r == ROLE_BACKUP) || (s1_role_r == ROLE_FALLBACK);
    end
  end

  // Capacity and score
  logic [CNT_W:0]    load_sum, limit_sum;
  logic              cap_ok;
  logic [WIDE_W:0]   remote_diff, score_sum;
  logic [WIDE_W-1:0] remote;
  logic              bad_count, count_ovf, usable, item_fb, item_cand;

  assign load_sum    = {1'b0, s1_served_r} + {1'b0, s1_queued_r};
  assign limit_sum   = {1'b0, s1_climit_r} + {1'b0, s1_qlimit_r};
  assign cap_ok      = (s1_climit_r == '0) || (load_sum < limit_sum);
  assign remote_diff = {1'b0, s1_global_r} - {1'b0, s1_own_r};
  assign bad_count   = s1_found_r && remote_diff[WIDE_W];
  assign remote      = s1_found_r ? remote_diff[WIDE_W-1:0] : '0;
  assign score_sum   = {1'b0, remote} + {1'b0, s1_local_r};
  assign count_ovf   = score_sum[WIDE_W];
  assign usable      = elig && cap_ok;
  assign item_fb     = !cache_usable_r || (usable && (!s1_ok_r || bad_count || count_ovf));
  assign item_cand   = usable && !item_fb;

  // Scoring register: valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_room) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  // Scoring register: payload
  always_ff @(posedge clk) begin
    if (s2_room && s1_valid_r) begin
      s2_idx_r   <= s1_idx_r;
      s2_cand_r  <= item_cand;
      s2_fb_r    <= item_fb;
      s2_score_r <= score_sum[WIDE_W-1:0];
      s2_last_r  <= s1_last_r;
    end
  end

  // Tie draw: step the generator and scale by the tie count
  logic [PRNG_W-1:0]       prng_a, prng_b, prng_step;
  logic [TIE_W-1:0]        tie_inc;
  logic [PRNG_W+TIE_W-1:0] draw_prod;
  logic                    avoid_hit;

  assign prng_a    = prng_r ^ (prng_r << 13);
  assign prng_b    = prng_a ^ (prng_a >> 17);
  assign prng_step = prng_b ^ (prng_b << 5);
  assign tie_inc   = (tie_count_r != TIE_MAX) ? tie_count_r + 1'b1 : tie_count_r;
  assign draw_prod = (PRNG_W+TIE_W)'(prng_step) * (PRNG_W+TIE_W)'(tie_inc);
  assign avoid_hit = (avoid_r < AVOID_W'(MAX_SERVERS)) && (avoid_r[IDX_W-1:0] == s2_idx_r);

  // Running best update
  always_comb begin
    best_valid_nxt = best_valid_r;
    best_index_nxt = best_index_r;
    best_cost_nxt  = best_cost_r;
    tie_count_nxt  = tie_count_r;
    avoided_nxt    = avoided_r;
    fallback_nxt   = fallback_r;
    prng_nxt       = prng_r;
    if (s2_take && !fallback_r) begin
      if (s2_fb_r) begin
        fallback_nxt = 1'b1;
      end else if (s2_cand_r) begin
        if (avoid_hit) begin
          avoided_nxt = 1'b1;
        end else if (!best_valid_r || (s2_score_r < best_cost_r)) begin
          best_valid_nxt = 1'b1;
          best_index_nxt = s2_idx_r;
          best_cost_nxt  = s2_score_r;
          tie_count_nxt  = TIE_W'(1);
        end else if (s2_score_r == best_cost_r) begin
          tie_count_nxt = tie_inc;
          prng_nxt      = prng_step;
          if (draw_prod[PRNG_W+TIE_W-1:PRNG_W] == '0) begin
            best_index_nxt = s2_idx_r;
          end
        end
      end
    end
  end

  // Pass result
  outcome_t         res_outcome;
  logic [IDX_W-1:0] res_server;
  always_comb begin
    priority if (fallback_nxt) begin
      res_outcome = OUT_FALLBACK;
      res_server  = '0;
    end else if (best_valid_nxt) begin
      res_outcome = OUT_CHOSEN;
      res_server  = best_index_nxt;
    end else if (avoided_nxt) begin
      res_outcome = OUT_CHOSEN;
      res_server  = avoid_r[IDX_W-1:0];
    end else begin
      res_outcome = OUT_NONE;
      res_server  = '0;
    end
  end

  // Pass state registers; cleared after the last request of a pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
      best_index_r <= '0;
      best_cost_r  <= '1;
      tie_count_r  <= '0;
      avoided_r    <= 1'b0;
      fallback_r   <= 1'b0;
    end else if (s2_take && s2_last_r) begin
      best_valid_r <= 1'b0;
      best_index_r <= '0;
      best_cost_r  <= '1;
      tie_count_r  <= '0;
      avoided_r    <= 1'b0;
      fallback_r   <= 1'b0;
    end else begin
      best_valid_r <= best_valid_nxt;
      best_index_r <= best_index_nxt;
      best_cost_r  <= best_cost_nxt;
      tie_count_r  <= tie_count_nxt;
      avoided_r    <= avoided_nxt;
      fallback_r   <= fallback_nxt;
    end
  end

  // Generator; a zero seed loads as one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prng_r <= PRNG_W'(1);
    end else if (cfg_fire && (cfg_ch.index == REG_SEED)) begin
      prng_r <= (cfg_ch.data[PRNG_W-1:0] == '0) ? PRNG_W'(1) : cfg_ch.data[PRNG_W-1:0];
    end else begin
      prng_r <= prng_nxt;
    end
  end

  // Result register: valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_take && s2_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (s2_take && s2_last_r) begin
      out_outcome_r <= res_outcome;
      out_server_r  <= res_server;
    end
  end

  // Checks
  a_prng_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    prng_r != '0)
    else $error("tie generator reached zero");

  a_best_has_tie: assert property (@(posedge clk) disable iff (!rst_n)
    best_valid_r |-> (tie_count_r != '0))
    else $error("best server held with zero tie count");

  a_fallback_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_outcome_r != OUT_CHOSEN)) |-> (out_server_r == '0))
    else $error("nonzero server index on a result without a chosen server");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r)
    else $error("stalled result dropped");

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
  import lcss_pkg::*;

  localparam int TOTAL_REQUESTS = 1150;
  localparam int TIE_RUN        = 520;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int REPORT_MAX     = 10;

  // One server request of a selection pass
  typedef struct {
    bit [7:0]  idx;
    role_t     role;
    bit [31:0] served;
    bit [31:0] queued;
    bit [31:0] conn_limit;
    bit [31:0] queue_limit;
    bit        lookup_ok;
    bit        remote_found;
    bit [63:0] global_cnt;
    bit [63:0] own_cnt;
    bit [63:0] local_cnt;
    bit        last;
  } req_t;

  typedef struct {
    outcome_t outcome;
    bit [7:0] server;
  } pick_t;

  typedef struct {
    bit        has_active;
    bit        has_fallback;
    bit        cache_ok;
    bit [8:0]  avoid;
    bit [31:0] seed;
  } cfg_t;

  // Predicts the pick of every pass and checks the returned picks in order
  class pick_scoreboard;
    bit        has_active;
    bit        has_fallback;
    bit        cache_ok;
    bit [8:0]  avoid_idx;
    bit [31:0] gen_word;

    bit        best_valid;
    bit [7:0]  best_idx;
    bit [63:0] best_cost;
    bit [8:0]  tie_cnt;
    bit        avoided_seen;
    bit        falling_back;

    pick_t expected_picks[$];
    int    errors;
    int    checked;
    int    tie_draws;
    int    picks_by_outcome[3];

    function new();
      has_active   = 1'b0;
      has_fallback = 1'b0;
      cache_ok     = 1'b0;
      avoid_idx    = 9'd256;
      gen_word     = 32'd1;
      errors       = 0;
      checked      = 0;
      tie_draws    = 0;
      picks_by_outcome = '{0, 0, 0};
      clear_pass();
    endfunction

    function void clear_pass();
      best_valid   = 1'b0;
      best_idx     = 8'd0;
      best_cost    = '1;
      tie_cnt      = 9'd0;
      avoided_seen = 1'b0;
      falling_back = 1'b0;
    endfunction

    function void write_reg(cfg_reg_t r, bit [31:0] d);
      case (r)
        REG_HAS_ACTIVE:   has_active = d[0];
        REG_HAS_FALLBACK: has_fallback = d[0];
        REG_CACHE_USABLE: cache_ok = d[0];
        REG_AVOID:        avoid_idx = d[8:0];
        REG_SEED:         gen_word = (d == 32'd0) ? 32'd1 : d;
        default: ;
      endcase
    endfunction

    // Score one server and fold it into the running best
    function void weigh_server(req_t q);
      bit        eligible;
      bit [63:0] remote;
      bit [63:0] score;
      bit [63:0] prod;
      remote = 64'd0;
      if (!cache_ok) falling_back = 1'b1;
      if (falling_back) return;
      if (q.role == ROLE_OFF) eligible = 1'b0;
      else if (has_active) eligible = (q.role == ROLE_ACTIVE);
      else if (has_fallback) eligible = (q.role == ROLE_FALLBACK);
      else eligible = (q.role == ROLE_BACKUP) || (q.role == ROLE_FALLBACK);
      if (!eligible) return;
      // capacity check on 64-bit sums
      if (q.conn_limit != 32'd0 &&
          !(64'(q.served) + 64'(q.queued) < 64'(q.conn_limit) + 64'(q.queue_limit)))
        return;
      if (!q.lookup_ok) begin
        falling_back = 1'b1;
        return;
      end
      if (q.remote_found) begin
        if (q.global_cnt < q.own_cnt) begin
          falling_back = 1'b1;
          return;
        end
        remote = q.global_cnt - q.own_cnt;
      end
      if (q.local_cnt > ~remote) begin
        falling_back = 1'b1;
        return;
      end
      score = remote + q.local_cnt;
      // avoided server is noted only after the fallback checks
      if (avoid_idx < MAX_SERVERS && avoid_idx[7:0] == q.idx) begin
        avoided_seen = 1'b1;
        return;
      end
      if (!best_valid || score < best_cost) begin
        best_valid = 1'b1;
        best_idx   = q.idx;
        best_cost  = score;
        tie_cnt    = 9'd1;
      end else if (score == best_cost) begin
        if (tie_cnt != TIE_MAX) tie_cnt++;
        gen_word ^= gen_word << 13;
        gen_word ^= gen_word >> 17;
        gen_word ^= gen_word << 5;
        prod = 64'(gen_word) * 64'(tie_cnt);
        tie_draws++;
        if (prod[63:32] == 32'd0) best_idx = q.idx;
      end
    endfunction

    function void note_request(req_t q);
      pick_t p;
      weigh_server(q);
      if (!q.last) return;
      if (falling_back) p = '{OUT_FALLBACK, 8'd0};
      else if (best_valid) p = '{OUT_CHOSEN, best_idx};
      else if (avoided_seen) p = '{OUT_CHOSEN, avoid_idx[7:0]};
      else p = '{OUT_NONE, 8'd0};
      expected_picks.push_back(p);
      clear_pass();
    endfunction

    function void check_pick(logic [1:0] oc, logic [7:0] sel);
      pick_t want;
      if (expected_picks.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected pick: outcome %0d server %0d", oc, sel);
        return;
      end
      want = expected_picks.pop_front();
      checked++;
      picks_by_outcome[want.outcome]++;
      if (oc !== want.outcome || sel !== want.server) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("pick #%0d: expected outcome %0d server %0d, got outcome %0d server %0d",
                   checked, want.outcome, want.server, oc, sel);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;

  lcss_in_if  in_if ();
  lcss_out_if out_if ();
  lcss_cfg_if cfg_if ();

  least_conn_server_select dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  pick_scoreboard sb;
  cfg_t cur_cfg;
  int   sent = 0;
  int   passes = 0;
  int   settings = 0;
  bit   tx_quiet = 1'b0;
  bit   rx_quiet = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog
  initial begin
    wait (cycle_count == TIMEOUT_CYCLES);
    $display("timeout after %0d cycles, %0d picks outstanding",
             cycle_count, sb.expected_picks.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Send one request, with a random gap ahead of it
  task automatic push_request(input req_t q);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.server_index  <= q.idx;
    in_if.server_role   <= q.role;
    in_if.served        <= q.served;
    in_if.queued        <= q.queued;
    in_if.conn_limit    <= q.conn_limit;
    in_if.queue_limit   <= q.queue_limit;
    in_if.lookup_ok     <= q.lookup_ok;
    in_if.remote_found  <= q.remote_found;
    in_if.cached_total  <= q.global_cnt;
    in_if.cached_self   <= q.own_cnt;
    in_if.current_local <= q.local_cnt;
    in_if.last_server   <= q.last;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    sb.note_request(q);
    sent++;
    if (q.last) passes++;
  endtask

  // Drain all picks, then let the pipeline empty
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.expected_picks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write every register (seed optional) from one setting
  task automatic apply_setting(input cfg_t c, input bit load_seed);
    cfg_reg_t  r;
    bit [31:0] d;
    for (int i = 0; i < 5; i++) begin
      r = cfg_reg_t'(i);
      if (r == REG_SEED && !load_seed) continue;
      case (r)
        REG_HAS_ACTIVE:   d = 32'(c.has_active);
        REG_HAS_FALLBACK: d = 32'(c.has_fallback);
        REG_CACHE_USABLE: d = 32'(c.cache_ok);
        REG_AVOID:        d = 32'(c.avoid);
        default:          d = c.seed;
      endcase
      cfg_if.valid <= 1'b1;
      cfg_if.index <= r;
      cfg_if.data  <= d;
      @(posedge clk);
      while (cfg_if.ready !== 1'b1) @(posedge clk);
      sb.write_reg(r, d);
    end
    cfg_if.valid <= 1'b0;
    cur_cfg = c;
    settings++;
  endtask

  // Clean request: lookup good, no remote entry, unlimited capacity
  function automatic req_t plain_request(bit [7:0] idx, role_t role, bit [63:0] lcount,
                                         bit last);
    req_t q;
    q.idx          = idx;
    q.role         = role;
    q.served       = 32'd0;
    q.queued       = 32'd0;
    q.conn_limit   = 32'd0;
    q.queue_limit  = 32'd0;
    q.lookup_ok    = 1'b1;
    q.remote_found = 1'b0;
    q.global_cnt   = 64'd0;
    q.own_cnt      = 64'd0;
    q.local_cnt    = lcount;
    q.last         = last;
    return q;
  endfunction

  // Mostly eligible servers with small counts so ties are common
  function automatic req_t rand_request(bit last);
    req_t q;
    int   k;
    q.idx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
    if ($urandom_range(0, 4) == 0) q.role = role_t'($urandom_range(0, 3));
    else if (cur_cfg.has_active) q.role = ROLE_ACTIVE;
    else if (cur_cfg.has_fallback) q.role = ROLE_FALLBACK;
    else q.role = $urandom_range(0, 1) ? ROLE_BACKUP : ROLE_FALLBACK;
    k = $urandom_range(0, 3);
    case (k)
      0: begin
        q.served = $urandom; q.queued = $urandom;
        q.conn_limit = 32'd0; q.queue_limit = $urandom;
      end
      1: begin
        q.served = $urandom_range(0, 7); q.queued = $urandom_range(0, 7);
        q.conn_limit = $urandom_range(1, 8); q.queue_limit = $urandom_range(0, 8);
      end
      2: begin
        q.served = $urandom; q.queued = $urandom;
        q.conn_limit = $urandom; q.queue_limit = $urandom;
      end
      default: begin
        q.served = $urandom_range(0, 3); q.queued = $urandom_range(0, 3);
        q.conn_limit = 32'd0; q.queue_limit = $urandom_range(0, 3);
      end
    endcase
    q.lookup_ok    = ($urandom_range(0, 39) != 0);
    q.remote_found = 1'($urandom_range(0, 1));
    q.own_cnt = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                            : 64'($urandom_range(0, 7));
    q.global_cnt = q.own_cnt + 64'($urandom_range(0, 3));
    q.local_cnt = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
                                               : 64'($urandom_range(0, 3));
    // occasional inconsistent counts, overflow and fully random counts
    k = $urandom_range(0, 49);
    if (k == 0) begin
      q.remote_found = 1'b1;
      q.own_cnt      = q.own_cnt | 64'd1;
      q.global_cnt   = q.own_cnt - 64'd1;
    end else if (k == 1) begin
      q.remote_found = 1'b1;
      q.global_cnt   = '1;
      q.own_cnt      = 64'd0;
      q.local_cnt    = 64'($urandom_range(1, 5));
    end else if (k == 2) begin
      q.global_cnt = {$urandom, $urandom};
      q.own_cnt    = {$urandom, $urandom};
      q.local_cnt  = {$urandom, $urandom};
    end
    q.last = last;
    return q;
  endfunction

  // Result side: random stalls with quiet stretches
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (out_if.valid !== 1'b1) @(posedge clk);
      sb.check_pick(out_if.outcome, out_if.selected_server);
    end
  end

  // Stimulus
  initial begin
    cfg_t c;
    req_t q;
    int   npass;
    int   len;
    bit   saturated;
    saturated = 1'b0;
    sb = new();
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.server_index  <= '0;
    in_if.server_role   <= ROLE_OFF;
    in_if.served        <= '0;
    in_if.queued        <= '0;
    in_if.conn_limit    <= '0;
    in_if.queue_limit   <= '0;
    in_if.lookup_ok     <= 1'b0;
    in_if.remote_found  <= 1'b0;
    in_if.cached_total  <= '0;
    in_if.cached_self   <= '0;
    in_if.current_local <= '0;
    in_if.last_server   <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_HAS_ACTIVE;
    cfg_if.data         <= '0;
    cur_cfg = '{has_active: 1'b0, has_fallback: 1'b0, cache_ok: 1'b0,
                avoid: 9'd256, seed: 32'd1};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // cache unusable after reset: pass falls back
    push_request(plain_request(8'd3, ROLE_ACTIVE, 64'd0, 1'b1));
    settle();
    c = '{has_active: 1'b1, has_fallback: 1'b0, cache_ok: 1'b1, avoid: 9'd256, seed: 32'd0};
    apply_setting(c, 1'b1);

    // roles under active servers, a full server with a failed lookup
    push_request(plain_request(8'd5, ROLE_ACTIVE, 64'd10, 1'b0));
    push_request(plain_request(8'd6, ROLE_BACKUP, 64'd0, 1'b0));
    push_request(plain_request(8'd7, ROLE_OFF, 64'd0, 1'b0));
    q = plain_request(8'd9, ROLE_ACTIVE, 64'd0, 1'b1);
    q.served = '1; q.queued = '1; q.conn_limit = '1; q.queue_limit = '1;
    q.lookup_ok = 1'b0;
    push_request(q);

    // three-way tie, remote and local scoring, capacity just met
    q = plain_request(8'd1, ROLE_ACTIVE, 64'd0, 1'b0);
    q.remote_found = 1'b1; q.global_cnt = 64'd5; q.own_cnt = 64'd2;
    push_request(q);
    push_request(plain_request(8'd2, ROLE_ACTIVE, 64'd3, 1'b0));
    q = plain_request(8'd3, ROLE_ACTIVE, 64'd3, 1'b1);
    q.conn_limit = 32'd5; q.served = 32'd2; q.queued = 32'd2;
    push_request(q);

    // failed lookup
    q = plain_request(8'd0, ROLE_ACTIVE, 64'd0, 1'b0);
    q.lookup_ok = 1'b0;
    push_request(q);
    push_request(plain_request(8'd255, ROLE_ACTIVE, 64'd1, 1'b1));

    // global below own
    q = plain_request(8'd4, ROLE_ACTIVE, 64'd0, 1'b0);
    q.remote_found = 1'b1; q.global_cnt = 64'd1; q.own_cnt = 64'd2;
    push_request(q);
    push_request(plain_request(8'd10, ROLE_ACTIVE, 64'd0, 1'b1));

    // 64-bit score overflow
    q = plain_request(8'd8, ROLE_ACTIVE, 64'd1, 1'b0);
    q.remote_found = 1'b1; q.global_cnt = '1; q.own_cnt = 64'd0;
    push_request(q);
    push_request(plain_request(8'd11, ROLE_ACTIVE, 64'd0, 1'b1));

    // maximum score, unlimited capacity with full counters
    q = plain_request(8'd12, ROLE_ACTIVE, '1, 1'b1);
    q.served = '1; q.queued = '1;
    q.remote_found = 1'b1; q.global_cnt = '1; q.own_cnt = '1;
    push_request(q);

    // nothing eligible
    push_request(plain_request(8'd13, ROLE_BACKUP, 64'd0, 1'b0));
    push_request(plain_request(8'd14, ROLE_FALLBACK, 64'd0, 1'b1));

    // designated fallback tier with an avoided server
    settle();
    c = '{has_active: 1'b0, has_fallback: 1'b1, cache_ok: 1'b1, avoid: 9'd20,
          seed: 32'hFFFF_FFFF};
    apply_setting(c, 1'b1);
    push_request(plain_request(8'd20, ROLE_FALLBACK, 64'd0, 1'b0));
    push_request(plain_request(8'd21, ROLE_BACKUP, 64'd0, 1'b1));
    push_request(plain_request(8'd20, ROLE_FALLBACK, 64'd0, 1'b0));
    push_request(plain_request(8'd22, ROLE_FALLBACK, 64'd100, 1'b1));

    // any backup tier, out-of-range avoid value
    settle();
    c = '{has_active: 1'b0, has_fallback: 1'b0, cache_ok: 1'b1, avoid: 9'd511,
          seed: 32'd1};
    apply_setting(c, 1'b0);
    push_request(plain_request(8'd30, ROLE_BACKUP, 64'd9, 1'b0));
    push_request(plain_request(8'd31, ROLE_FALLBACK, 64'd2, 1'b1));

    // random phases, each under a new setting
    while (sent < TOTAL_REQUESTS) begin
      settle();
      c.has_active   = 1'($urandom_range(0, 1));
      c.has_fallback = 1'($urandom_range(0, 1));
      c.cache_ok     = ($urandom_range(0, 5) != 0);
      case ($urandom_range(0, 4))
        0:       c.avoid = 9'd256;
        1:       c.avoid = 9'($urandom_range(257, 511));
        2:       c.avoid = $urandom_range(0, 1) ? 9'd0 : 9'd255;
        default: c.avoid = 9'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 5))
        0:       c.seed = 32'd0;
        1:       c.seed = 32'hFFFF_FFFF;
        default: c.seed = $urandom;
      endcase
      apply_setting(c, $urandom_range(0, 2) != 0);
      npass = $urandom_range(6, 16);
      for (int p = 0; p < npass && sent < TOTAL_REQUESTS; p++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) push_request(rand_request(k == len - 1));
      end

      // one long all-tie pass drives the tie counter into saturation
      if (!saturated && sent >= 400) begin
        settle();
        c = '{has_active: 1'b1, has_fallback: 1'b0, cache_ok: 1'b1, avoid: 9'd256,
              seed: $urandom};
        apply_setting(c, 1'b1);
        for (int k = 0; k < TIE_RUN; k++)
          push_request(plain_request(8'($urandom), ROLE_ACTIVE, 64'd7, k == TIE_RUN - 1));
        saturated = 1'b1;
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.expected_picks.size() != 0) begin
      sb.errors += sb.expected_picks.size();
      $display("%0d picks never returned", sb.expected_picks.size());
    end

    $display("%0d requests in %0d passes over %0d register settings, %0d tie draws",
             sent, passes, settings, sb.tie_draws);
    $display("%0d picks checked: %0d chosen, %0d none eligible, %0d fallback; %0d errors",
             sb.checked, sb.picks_by_outcome[OUT_CHOSEN], sb.picks_by_outcome[OUT_NONE],
             sb.picks_by_outcome[OUT_FALLBACK], sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* least_conn_server_select.f */
rtl/lcss_pkg.sv
rtl/lcss_ifs.sv
rtl/least_conn_server_select.sv
verif/tb.sv
